// ===== rtl/core/psp_pkg.sv =====
// Package for the patch select panel controller.
// Holds field widths, mode and opcode codes, glyph codes and the segment table.
// No dependencies; used by every file of the block.
`default_nettype none

package psp_pkg;

   // Field and state widths
   localparam int SEL_BITS      = 8;
   localparam int CNT_BITS      = 16;
   localparam int ENC_BITS      = 14;
   localparam int MODE_BITS     = 3;
   localparam int SEGMENT_WIDTH = 7;
   localparam int GLYPH_BITS    = 5;
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Counter reload value after reset
   localparam logic [CNT_BITS-1:0] RELOAD_RESET = 16'd200;

   // Register index of reload_ticks (byte address divided by four)
   localparam logic REG_RELOAD = 1'b0;

   // Item opcodes
   localparam logic OP_TICK        = 1'b0;
   localparam logic OP_MODE_CHANGE = 1'b1;

   // Operating modes
   localparam logic [MODE_BITS-1:0] MODE_STARTUP   = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_LOAD      = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_RUN       = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_CONFIGURE = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_STREAM    = 3'd4;
   localparam logic [MODE_BITS-1:0] MODE_ERROR     = 3'd5;

   // Special glyph codes
   localparam logic [GLYPH_BITS-1:0] GLYPH_E     = 5'd14;
   localparam logic [GLYPH_BITS-1:0] GLYPH_BLANK = 5'd16;
   localparam logic [GLYPH_BITS-1:0] GLYPH_U     = 5'd17;
   localparam logic [GLYPH_BITS-1:0] GLYPH_L     = 5'd18;

   // One input item
   typedef struct packed {
      logic                  opcode;
      logic [MODE_BITS-1:0]  operating_mode;
      logic                  error_pending;
      logic [ENC_BITS-1:0]   encoder_count;
      logic                  button_pressed;
      logic [SEL_BITS-1:0]   running_patch;
      logic [SEL_BITS-1:0]   patch_count;
   } item_type;

   // One result item
   typedef struct packed {
      logic [SEGMENT_WIDTH-1:0] segments_n;
      logic                  dot_n;
      logic                  display_write;
      logic                  encoder_write;
      logic [SEL_BITS-1:0]   encoder_value;
      logic                  load_request;
      logic                  save_request;
      logic [SEL_BITS-1:0]   selected_patch;
      logic                  mode_request;
      logic                  mode_request_error;
      logic                  clear_error;
   } result_type;

   // Panel state carried from item to item
   typedef struct packed {
      logic [SEL_BITS-1:0]   selection;
      logic [CNT_BITS-1:0]   hold_counter;
   } state_type;

   // Segment pattern (active high, bit0 = segment a) for a glyph code
   function automatic logic [SEGMENT_WIDTH-1:0] glyph_bits(input logic [GLYPH_BITS-1:0] code);
      logic [SEGMENT_WIDTH-1:0] bits;
      begin
         case (code)
            5'd0:    bits = 7'h3f;
            5'd1:    bits = 7'h06;
            5'd2:    bits = 7'h5b;
            5'd3:    bits = 7'h4f;
            5'd4:    bits = 7'h66;
            5'd5:    bits = 7'h6d;
            5'd6:    bits = 7'h7d;
            5'd7:    bits = 7'h07;
            5'd8:    bits = 7'h7f;
            5'd9:    bits = 7'h67;
            5'd10:   bits = 7'h77;
            5'd11:   bits = 7'h7c;
            5'd12:   bits = 7'h39;
            5'd13:   bits = 7'h5e;
            5'd14:   bits = 7'h79;
            5'd15:   bits = 7'h71;
            5'd16:   bits = 7'h00;
            5'd17:   bits = 7'h3e;
            5'd18:   bits = 7'h38;
            default: bits = 7'h00;
         endcase
         return bits;
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/psp_step.sv =====
// Per-item panel logic: next selection, next hold counter and the result item.
// Purely combinational; depends on psp_pkg.
`default_nettype none

module psp_step (
   input  psp_pkg::item_type                  item,
   input  psp_pkg::state_type                 state,
   input  logic [psp_pkg::CNT_BITS-1:0]       reload,
   output psp_pkg::result_type                result,
   output psp_pkg::state_type                 state_next
);
   import psp_pkg::*;

   logic [SEL_BITS-1:0] sel1;
   logic [SEL_BITS-1:0] hi;
   logic [SEL_BITS-1:0] clamped;
   logic [CNT_BITS-1:0] dec;
   logic [CNT_BITS-1:0] half;
   logic                expired;
   logic [GLYPH_BITS-1:0] digit;

   // Shared counter step and hold-dot threshold
   assign dec     = state.hold_counter - {{(CNT_BITS-1){1'b0}}, 1'b1};
   assign expired = (dec == '0);
   assign half    = reload >> 1;

   // Clamp the encoder to 1..patch_count-1
   always_comb begin
      hi = item.patch_count - {{(SEL_BITS-1){1'b0}}, 1'b1};
      if (item.patch_count <= {{(SEL_BITS-2){1'b0}}, 2'd1}) begin
         clamped = {{(SEL_BITS-1){1'b0}}, 1'b1};
      end else if (item.encoder_count < {{(ENC_BITS-SEL_BITS){1'b0}}, hi}) begin
         clamped = (item.encoder_count[SEL_BITS-1:0] == '0) ?
                   {{(SEL_BITS-1){1'b0}}, 1'b1} : item.encoder_count[SEL_BITS-1:0];
      end else begin
         clamped = hi;
      end
   end

   // Decide the step
   always_comb begin
      result            = '0;
      result.segments_n = '1;
      result.dot_n      = 1'b1;
      state_next        = state;
      sel1              = state.selection;
      digit             = '0;

      if (item.opcode == OP_MODE_CHANGE) begin
         state_next.selection = item.running_patch;
         result.encoder_write = 1'b1;
         result.encoder_value = item.running_patch;
      end else begin
         case (item.operating_mode)
            MODE_STARTUP: begin
               result.segments_n    = ~glyph_bits(GLYPH_BLANK);
               result.dot_n         = 1'b0;
               result.display_write = 1'b1;
            end
            MODE_LOAD: begin
               result.segments_n    = ~glyph_bits(GLYPH_L);
               result.display_write = 1'b1;
            end
            MODE_RUN: begin
               // Error flag or encoder follow-up
               if (item.error_pending) begin
                  result.mode_request       = 1'b1;
                  result.mode_request_error = 1'b1;
               end else if (item.encoder_count != {{(ENC_BITS-SEL_BITS){1'b0}},
                                                    state.selection}) begin
                  sel1 = clamped;
                  if (item.encoder_count != {{(ENC_BITS-SEL_BITS){1'b0}}, clamped}) begin
                     result.encoder_write = 1'b1;
                     result.encoder_value = clamped;
                  end
               end
               state_next.selection = sel1;
               digit = {1'b0, sel1[3:0]};

               if (item.running_patch != sel1) begin
                  // Differing selection: load on press, revert on timeout
                  result.segments_n    = ~glyph_bits(digit);
                  result.display_write = 1'b1;
                  if (!item.button_pressed) begin
                     if (expired) begin
                        state_next.hold_counter = reload;
                        state_next.selection    = item.running_patch;
                        result.encoder_write    = 1'b1;
                        result.encoder_value    = item.running_patch;
                     end else begin
                        state_next.hold_counter = dec;
                     end
                  end else begin
                     result.load_request = 1'b1;
                  end
               end else if (item.button_pressed && sel1 != '0) begin
                  // Held on the running patch: save on timeout
                  if (expired) begin
                     state_next.hold_counter = reload;
                     result.save_request     = 1'b1;
                  end else begin
                     state_next.hold_counter = dec;
                     result.segments_n       = ~glyph_bits(digit);
                     result.dot_n            = ~(dec > half);
                     result.display_write    = 1'b1;
                  end
               end else begin
                  result.segments_n       = ~glyph_bits(digit);
                  result.dot_n            = 1'b0;
                  result.display_write    = 1'b1;
                  state_next.hold_counter = reload;
               end
            end
            MODE_CONFIGURE: begin
               result.mode_request = 1'b1;
            end
            MODE_STREAM: begin
               result.segments_n    = ~glyph_bits(GLYPH_U);
               result.display_write = 1'b1;
            end
            MODE_ERROR: begin
               // Show the error glyph with a blinking dot; press clears the error
               result.segments_n       = ~glyph_bits(GLYPH_E);
               result.dot_n            = ~(state.hold_counter > half);
               result.display_write    = 1'b1;
               state_next.hold_counter = expired ? reload : dec;
               if (item.button_pressed) begin
                  result.clear_error  = 1'b1;
                  result.mode_request = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      result.selected_patch = state_next.selection;
   end

endmodule

`default_nettype wire

// ===== rtl/core/patch_select_panel_controller_core.sv =====
// Top level of the patch select panel controller: stream ports, CSR port,
// input register, result register and panel state. Depends on psp_pkg, psp_step.
//
// Usage:
//   req_* carries one item per transfer: a loop tick or a mode-change event
//   (req_tuser) with the panel inputs in req_tdata. rsp_* returns exactly one
//   result item per input item, in order, with display pins, encoder write-back,
//   load/save requests, mode requests and the selection after the step.
//   csr_* is an APB-style port holding reload_ticks at byte address 0.
// Pipeline: an accepted item is captured in the input register, then evaluated
//   into the result register once that register is free, and its result is
//   offered from there.
// Throughput: one item per cycle while rsp_tready stays high; the step is one
//   combinational pass between the input register and the result register,
//   and the panel state updates at the same edge the result is registered.
// Reset: reload_ticks returns to 200, selection to 0, the hold counter to 200,
//   and both pipeline registers are emptied.
// Stall: while rsp_tready is low the result holds; the input register still
//   fills, then req_tready drops until the result is taken.
`default_nettype none

module patch_select_panel_controller_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [2:0] operating_mode, [3] error_pending, [17:4] encoder_count,
   // [18] button_pressed, [26:19] running_patch, [34:27] patch_count, [39:35] zero
   input  logic [psp_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   // [0] opcode
   input  logic                                  req_tuser,
   // Result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [6:0] segments_n, [7] dot_n, [8] display_write, [9] encoder_write,
   // [17:10] encoder_value, [18] load_request, [19] save_request,
   // [27:20] selected_patch, [28] mode_request, [29] mode_request_error,
   // [30] clear_error, [31] zero
   output logic [psp_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   // Configuration port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [psp_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [psp_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [psp_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                  csr_pready
);
   import psp_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   item_type              item_ff, item_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_ff, rsp_in;
   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   reload_ff, reload_in;
   logic                  out_free;
   logic                  advance;
   logic                  csr_write;
   result_type            step_result;
   state_type             step_state;

   // Handshake control
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   // Unpack the transfer into an item
   always_comb begin
      item_in                = item_ff;
      if (req_tvalid && req_tready) begin
         item_in.opcode         = req_tuser;
         item_in.operating_mode = req_tdata[2:0];
         item_in.error_pending  = req_tdata[3];
         item_in.encoder_count  = req_tdata[17:4];
         item_in.button_pressed = req_tdata[18];
         item_in.running_patch  = req_tdata[26:19];
         item_in.patch_count    = req_tdata[34:27];
      end
   end

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !out_free);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
   assign rsp_in       = advance ? step_result : rsp_ff;
   assign state_in     = advance ? step_state : state_ff;

   // Panel step
   psp_step u_step (
      .item       (item_ff),
      .state      (state_ff),
      .reload     (reload_ff),
      .result     (step_result),
      .state_next (step_state)
   );

   // Configuration register
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reload_in  = (csr_write && csr_paddr[2] == REG_RELOAD) ?
                       csr_pwdata[CNT_BITS-1:0] : reload_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_RELOAD) ?
                       {{(CSR_DATA_BITS-CNT_BITS){1'b0}}, reload_ff} : '0;

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{selection: '0, hold_counter: RELOAD_RESET};
         reload_ff    <= RELOAD_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         reload_ff    <= reload_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   // Pack the result transfer
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0,
                        rsp_ff.clear_error,
                        rsp_ff.mode_request_error,
                        rsp_ff.mode_request,
                        rsp_ff.selected_patch,
                        rsp_ff.save_request,
                        rsp_ff.load_request,
                        rsp_ff.encoder_value,
                        rsp_ff.encoder_write,
                        rsp_ff.display_write,
                        rsp_ff.dot_n,
                        rsp_ff.segments_n};

endmodule

`default_nettype wire

// ===== rtl/core/psp_checker.sv =====
// Port-level checks for the patch select panel controller, bound to the top level.
// Depends on psp_pkg.
`default_nettype none

module psp_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic [psp_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   input  logic [psp_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [psp_pkg::CSR_DATA_BITS-1:0]     csr_prdata
);
   import psp_pkg::*;

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Dark display when pins are not written
   a_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[8] |-> rsp_tdata[7:0] == 8'hff)
      else $error("display pins not dark without display write");

   // Encoder value zero without encoder write
   a_enc_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[9] |-> rsp_tdata[17:10] == '0)
      else $error("encoder value without encoder write");

   // Error request and clear come only with a mode request
   a_mode_req: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[29] || rsp_tdata[30]) |-> rsp_tdata[28])
      else $error("mode request flags inconsistent");

   // Reload register reads its reset value after reset
   a_reload_reset: assert property (@(posedge clock)
      !reset && $past(reset) && csr_paddr[2] == REG_RELOAD |->
      csr_prdata == {{(CSR_DATA_BITS-CNT_BITS){1'b0}}, RELOAD_RESET})
      else $error("reload register not at reset value");

endmodule

bind patch_select_panel_controller_core psp_checker u_psp_checker (.*);

`default_nettype wire
